// File: rtl/upd_pkg.sv
// Package for the URL percent decoder: character codes, hex helpers,
// escape phase type and the queue entry passed from front to back end.
// No dependencies.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerF  = 8'h66;
  localparam logic [7:0] HexTen      = 8'd10;

  // Most bytes one input item can produce
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } upd_phase_e;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               count;  // 1 to 3 valid bytes, lowest first
    logic                     eoi;
  } upd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } upd_fifo_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= CharZero   && c <= CharNine)   ||
             (c >= CharUpperA && c <= CharUpperF) ||
             (c >= CharLowerA && c <= CharLowerF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CharLowerA) begin
      v = c - CharLowerA + HexTen;
    end else if (c >= CharUpperA) begin
      v = c - CharUpperA + HexTen;
    end else begin
      v = c - CharZero;
    end
    hex_value = v[3:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/upd_if.sv
// Stream interfaces for the URL percent decoder: encoded input and
// decoded output channels. Depends on nothing.
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_output;
  logic       last_of_run;

  modport source (output valid, output out_byte, output end_of_output,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input end_of_output,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/upd_front.sv
// Front end: accepts encoded bytes, tracks the escape phase and packs the
// bytes each item yields into one queue entry. Depends on upd_pkg, upd_if.
`default_nettype none

module upd_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  upd_in_if.sink             in_i,
  input  wire                full_i,
  output logic               push_o,
  output upd_pkg::upd_entry_t entry_o
);
  import upd_pkg::*;

  upd_phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic       go_plain;
  logic [7:0] c;
  logic [MaxBytes-1:0][7:0] bytes;
  logic [1:0] n;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;

  always_comb begin
    bytes    = '0;
    n        = 2'd0;
    phase_d  = phase_q;
    held_d   = held_q;
    go_plain = 1'b0;

    unique case (phase_q)
      PH_PCT: begin
        if (is_hex(c)) begin
          held_d  = c;
          phase_d = PH_DIGIT;
        end else begin
          bytes[0] = CharPercent;
          n        = 2'd1;
          go_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(c)) begin
          bytes[0] = {hex_value(held_q), hex_value(c)};
          n        = 2'd1;
          phase_d  = PH_IDLE;
        end else begin
          bytes[0] = CharPercent;
          bytes[1] = held_q;
          n        = 2'd2;
          go_plain = 1'b1;
        end
      end
      default: go_plain = 1'b1;
    endcase

    // Plain byte or broken escape: handle the byte afresh
    if (go_plain) begin
      if (c == CharPercent) begin
        phase_d = PH_PCT;
      end else begin
        phase_d  = PH_IDLE;
        bytes[n] = (c == CharPlus) ? CharSpace : c;
        n        = n + 2'd1;
      end
    end

    // Flush a pending escape on the final byte
    if (in_i.end_of_input) begin
      if (phase_d == PH_PCT) begin
        bytes[n] = CharPercent;
        n        = n + 2'd1;
      end else if (phase_d == PH_DIGIT) begin
        bytes[0] = CharPercent;
        bytes[1] = held_d;
        n        = 2'd2;
      end
      phase_d = PH_IDLE;
    end
  end

  assign push_o        = accept && (n != 2'd0);
  assign entry_o.bytes = bytes;
  assign entry_o.count = n;
  assign entry_o.eoi   = in_i.end_of_input;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/upd_fifo.sv
// Short queue of decoded entries between front and back end.
// Depends on upd_pkg.
`default_nettype none

module upd_fifo #(
  parameter int unsigned Depth = upd_pkg::QueueDepthDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  upd_pkg::upd_entry_t    entry_i,
  input  wire                    pop_i,
  output upd_pkg::upd_entry_t    head_o,
  output upd_pkg::upd_fifo_stat_t stat_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upd_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ok      = push_i && !stat_o.full;
  assign pop_ok       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_ok) - CntW'(pop_ok);
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/upd_back.sv
// Back end: walks the bytes of the head entry one per cycle into the output
// register unless stalled; pops the entry after its last byte. Depends on upd_pkg, upd_if.
`default_nettype none

module upd_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  upd_pkg::upd_entry_t     head_i,
  input  upd_pkg::upd_fifo_stat_t stat_i,
  output logic                    pop_o,
  upd_out_if.source               out_o
);
  import upd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, sel_byte;
  logic       eoo_q, lor_q;
  logic       avail, can_load, load, last;

  assign avail    = !stat_i.empty;
  assign can_load = !vld_q || out_o.ready;
  assign load     = avail && can_load;
  assign last     = (idx_q == head_i.count - 2'd1);
  assign pop_o    = load && last;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.bytes[0];
      2'd1:    sel_byte = head_i.bytes[1];
      2'd2:    sel_byte = head_i.bytes[2];
      default: sel_byte = head_i.bytes[0];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (can_load) begin
      vld_d = avail;
    end
    if (load) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      lor_q  <= last;
      eoo_q  <= last && head_i.eoi;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.end_of_output = eoo_q;
  assign out_o.last_of_run   = lor_q;

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder.sv
// URL percent decoder: one encoded byte in per cycle; "%hh" becomes one
// byte, '+' becomes a space, broken or unfinished escapes pass through
// literally, and each item yields zero to three decoded bytes. Input is
// taken every cycle while the entry queue (QueueDepth entries) has room;
// the output side delivers one byte per cycle while out_o.ready allows,
// and an item yields one output byte for an ordinary byte and up to three
// for a broken escape. Each byte passes through the entry queue and the
// output register. last_of_run marks each item's last byte, end_of_output the
// final byte of a string. Depends on upd_pkg, upd_if and the submodules.
`default_nettype none

module url_percent_decoder #(
  parameter int unsigned QueueDepth = upd_pkg::QueueDepthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  upd_in_if.sink     in_i,
  upd_out_if.source  out_o
);
  import upd_pkg::*;

  upd_entry_t     push_entry, head;
  upd_fifo_stat_t stat;
  logic           push, pop;

  upd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (stat.full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  upd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  upd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder.
`default_nettype none

module upd_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_eoo_i,
  input wire out_lor_i
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // The end of a string always closes the run of its item
  a_eoo_lor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eoo_i |-> out_lor_i)
    else $error("end_of_output without last_of_run");

  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid straight after reset");

  a_rst_ready: assert property (@(posedge clk_i)
    !rst_ni |-> in_ready_i)
    else $error("input not ready with the queue empty");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_eoo_i   (out_o.end_of_output),
  .out_lor_i   (out_o.last_of_run)
);

`default_nettype wire
